[sv/gcd_pkg.sv]
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared types, constants and helpers of the great-circle distance pipeline.
// ----------------------------------------------------------------------------
package gcd_pkg;

    // default phase width, 2^ANGLE_BITS is one turn
    localparam int ANGLE_BITS_DEFAULT = 32;

    // taylor series depth and resulting pipeline length of one series unit
    localparam int SERIES_TERMS = 7;
    localparam int SERIES_LAT   = 3 * SERIES_TERMS + 2;

    // result bits of the arc cosine search
    localparam int ACOS_BITS = 32;

    // q30 constants, and the reset sphere radius in q16.16
    localparam logic [31:0] ONE_Q30      = 32'd1073741824;
    localparam logic [31:0] HALF_PI_Q30  = 32'd1686629713;
    localparam logic [31:0] PI_Q30       = 32'd3373259426;
    localparam logic [31:0] RADIUS_RESET = 32'd225296174;

    // factorial factor pairs of the series terms
    localparam int unsigned COS_DIV [SERIES_TERMS] = '{2, 12, 30, 56, 90, 132, 182};
    localparam int unsigned SIN_DIV [SERIES_TERMS] = '{6, 20, 42, 72, 110, 156, 210};

    // floor(2^33 / divisor), quotient estimate is exact or one low
    localparam logic [32:0] COS_RECIP [SERIES_TERMS] = '{
        33'((65'd1 << 33) / 65'd2),   33'((65'd1 << 33) / 65'd12),
        33'((65'd1 << 33) / 65'd30),  33'((65'd1 << 33) / 65'd56),
        33'((65'd1 << 33) / 65'd90),  33'((65'd1 << 33) / 65'd132),
        33'((65'd1 << 33) / 65'd182)
    };
    localparam logic [32:0] SIN_RECIP [SERIES_TERMS] = '{
        33'((65'd1 << 33) / 65'd6),   33'((65'd1 << 33) / 65'd20),
        33'((65'd1 << 33) / 65'd42),  33'((65'd1 << 33) / 65'd72),
        33'((65'd1 << 33) / 65'd110), 33'((65'd1 << 33) / 65'd156),
        33'((65'd1 << 33) / 65'd210)
    };

    // quadrant of a phase
    typedef enum logic [1:0] {
        QUAD_FIRST,
        QUAD_SECOND,
        QUAD_THIRD,
        QUAD_FOURTH
    } quad_t;

    // input word
    typedef struct packed {
        logic signed [31:0] first_lat;
        logic signed [31:0] first_lon;
        logic signed [31:0] second_lat;
        logic signed [31:0] second_lon;
        logic [31:0]        circle_radius;
    } item_t;

    // result word
    typedef struct packed {
        logic [31:0] central_angle;
        logic [33:0] distance;
        logic        inside_res;
        logic        invalid;
    } result_t;

    // sideband through the trig front end
    typedef struct packed {
        quad_t [2:0] quad;
        logic [31:0] radius;
    } front_side_t;

    // sideband through the arc cosine search
    typedef struct packed {
        logic [31:0]        theta;
        logic signed [31:0] arg;
        logic [31:0]        radius;
        logic               invalid;
        logic               neg;
        logic               over;
    } search_side_t;

    // q30 product, magnitude truncated then signed
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic        neg;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [63:0] prod;
        logic [31:0] m;
        neg  = a[31] ^ b[31];
        ma   = a[31] ? 32'(-a) : 32'(a);
        mb   = b[31] ? 32'(-b) : 32'(b);
        prod = {32'd0, ma} * {32'd0, mb};
        m    = prod[61:30];
        return neg ? $signed(32'(-m)) : $signed(m);
    endfunction

endpackage

[sv/great_circle_distance_unit.sv]
// ----------------------------------------------------------------------------
// great_circle_distance_unit
// Central angle and distance between two positions by the spherical law of
// cosines, with a circle-of-equal-altitude test.
// ----------------------------------------------------------------------------
// The item channel takes a word of two positions and a circle radius when
// item_valid is high and item_stall is low. The result channel offers one word
// per item on result_valid, taken when result_stall is low.
// The cfg channel writes the sphere radius when cfg_valid and cfg_ready are
// high; cfg_ready is always high. Write it only while no item is in flight.
// Phase scaling, series sine/cosine and products come first, then 32 search
// steps (one cosine series unit per result bit), then the output register.
// One item is taken every cycle while item_stall is low.
// The whole pipeline advances together; it freezes only while a result is
// offered and result_stall is high, and item_stall is high exactly then.
// Reset clears every valid bit and reloads the sphere radius with its
// nautical-mile default.
// ----------------------------------------------------------------------------
module great_circle_distance_unit #(
    parameter int ANGLE_BITS = gcd_pkg::ANGLE_BITS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  gcd_pkg::item_t  item,
    output logic            result_valid,
    input  logic            result_stall,
    output gcd_pkg::result_t result,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [31:0]     cfg_data
);
    import gcd_pkg::*;

    localparam int QS  = ANGLE_BITS - 2;
    localparam int RE  = (QS < 17) ? 17 : QS;
    localparam int PHW = RE + 16;
    localparam int XW  = RE + 33;

    logic advance;

    logic [31:0] radius_reg;

    // front end registers
    quad_t              quad0_reg [3];
    logic [QS-1:0]      r0_reg    [3];
    logic [31:0]        rad0_reg;
    logic               v0_reg;
    quad_t              quad1_reg [3];
    logic [PHW-1:0]     ph_reg    [3];
    logic [47:0]        pl_reg    [3];
    logic [31:0]        rad1_reg;
    logic               v1_reg;
    quad_t              quad2_reg [3];
    logic [30:0]        x_reg     [3];
    logic [31:0]        rad2_reg;
    logic               v2_reg;
    front_side_t        fside_reg [SERIES_LAT];
    logic               fv_reg    [SERIES_LAT];
    logic signed [31:0] s_reg     [3];
    logic signed [31:0] c_reg     [3];
    logic [31:0]        rad3_reg;
    logic               v3_reg;
    logic signed [31:0] m1_reg;
    logic signed [31:0] m2_reg;
    logic signed [31:0] c2_reg;
    logic [31:0]        rad4_reg;
    logic               v4_reg;
    logic signed [31:0] m3_reg;
    logic signed [31:0] m2b_reg;
    logic [31:0]        rad5_reg;
    logic               v5_reg;

    // search registers
    search_side_t       dec_reg  [ACOS_BITS+1];
    logic               dv_reg   [ACOS_BITS+1];
    search_side_t       prep_reg [ACOS_BITS];
    logic [30:0]        px_reg   [ACOS_BITS];
    logic               pv_reg   [ACOS_BITS];
    search_side_t       dly_reg  [ACOS_BITS][SERIES_LAT];
    logic               dlyv_reg [ACOS_BITS][SERIES_LAT];

    result_t            result_reg;
    logic               result_valid_reg;

    // next values
    quad_t              quad0_next [3];
    logic [QS-1:0]      r0_next    [3];
    logic [PHW-1:0]     ph_next    [3];
    logic [47:0]        pl_next    [3];
    logic [30:0]        x_next     [3];
    logic signed [31:0] s_next     [3];
    logic signed [31:0] c_next     [3];
    search_side_t       dec0_next;
    search_side_t       prep_next  [ACOS_BITS];
    logic [30:0]        px_next    [ACOS_BITS];
    search_side_t       dec_next   [ACOS_BITS];
    result_t            result_next;

    logic [30:0]        sin_y  [3];
    logic [30:0]        cos_y  [3];
    logic [30:0]        acos_y [ACOS_BITS];

    // whole pipeline moves unless a result is held
    assign advance    = !(result_valid_reg && result_stall);
    assign item_stall = !advance;
    assign cfg_ready  = 1'b1;

    // sphere radius register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= RADIUS_RESET;
        else if (cfg_valid)
            radius_reg <= cfg_data;
    end

    // phase scaling: quadrant split and remainder times pi/2
    always_comb
    begin
        logic [31:0]            ang [3];
        logic [ANGLE_BITS+31:0] wide;
        logic [ANGLE_BITS-1:0]  phase;
        logic [RE-1:0]          rext;
        logic [XW-1:0]          xfull;
        logic [XW-1:0]          xs;
        ang[0] = item.first_lat;
        ang[1] = item.second_lat;
        ang[2] = item.first_lon - item.second_lon;
        for (int a = 0; a < 3; a++)
        begin
            wide  = {ang[a], ANGLE_BITS'(0)};
            phase = wide[ANGLE_BITS+31 -: ANGLE_BITS];
            quad0_next[a] = quad_t'(phase[ANGLE_BITS-1 -: 2]);
            r0_next[a]    = phase[QS-1:0];
            rext          = RE'(r0_reg[a]);
            ph_next[a]    = PHW'(rext[RE-1:16]) * PHW'(HALF_PI_Q30);
            pl_next[a]    = 48'(rext[15:0]) * 48'(HALF_PI_Q30);
            xfull         = XW'({ph_reg[a], 16'd0}) + XW'(pl_reg[a]);
            xs            = xfull >> QS;
            x_next[a]     = xs[30:0];
        end
    end

    // sine and cosine of the three angles
    for (genvar a = 0; a < 3; a++)
    begin : g_trig
        gcd_series #(.IS_SIN(1'b1)) u_sin (
            .clk (clk),
            .en  (advance),
            .x   (x_reg[a]),
            .y   (sin_y[a])
        );
        gcd_series #(.IS_SIN(1'b0)) u_cos (
            .clk (clk),
            .en  (advance),
            .x   (x_reg[a]),
            .y   (cos_y[a])
        );
    end

    // quadrant symmetry, product sum and argument clamp
    always_comb
    begin
        logic signed [31:0] sv;
        logic signed [31:0] cv;
        logic signed [32:0] sum33;
        for (int a = 0; a < 3; a++)
        begin
            sv = $signed({1'b0, sin_y[a]});
            cv = $signed({1'b0, cos_y[a]});
            case (fside_reg[SERIES_LAT-1].quad[a])
                QUAD_FIRST:
                begin
                    s_next[a] = sv;
                    c_next[a] = cv;
                end
                QUAD_SECOND:
                begin
                    s_next[a] = cv;
                    c_next[a] = -sv;
                end
                QUAD_THIRD:
                begin
                    s_next[a] = -sv;
                    c_next[a] = -cv;
                end
                default:
                begin
                    // fourth quadrant
                    s_next[a] = -cv;
                    c_next[a] = sv;
                end
            endcase
        end
        sum33 = 33'(m3_reg) + 33'(m2b_reg);
        dec0_next        = '0;
        dec0_next.radius = rad5_reg;
        if (sum33 > $signed({1'b0, ONE_Q30}))
        begin
            dec0_next.arg     = $signed(ONE_Q30);
            dec0_next.invalid = 1'b1;
        end
        else if (sum33 < -$signed({1'b0, ONE_Q30}))
        begin
            dec0_next.arg     = -$signed(ONE_Q30);
            dec0_next.invalid = 1'b1;
        end
        else
        begin
            dec0_next.arg = sum33[31:0];
        end
    end

    // arc cosine search: candidate set-up and keep-or-drop per bit
    always_comb
    begin
        logic [31:0]        cand;
        logic signed [31:0] cosv;
        logic [31:0]        pick;
        search_side_t       sd;
        for (int i = 0; i < ACOS_BITS; i++)
        begin
            cand         = dec_reg[i].theta | (32'd1 << (ACOS_BITS - 1 - i));
            prep_next[i]      = dec_reg[i];
            prep_next[i].over = cand > PI_Q30;
            prep_next[i].neg  = cand > HALF_PI_Q30;
            if (cand > PI_Q30)
                px_next[i] = '0;
            else if (cand > HALF_PI_Q30)
                px_next[i] = 31'(PI_Q30 - cand);
            else
                px_next[i] = cand[30:0];

            sd   = dly_reg[i][SERIES_LAT-1];
            cosv = sd.neg ? -$signed({1'b0, acos_y[i]}) : $signed({1'b0, acos_y[i]});
            pick = sd.theta | (32'd1 << (ACOS_BITS - 1 - i));
            dec_next[i] = sd;
            if (!sd.over && (cosv >= sd.arg))
                dec_next[i].theta = pick;
        end
    end

    for (genvar i = 0; i < ACOS_BITS; i++)
    begin : g_search
        gcd_series #(.IS_SIN(1'b0)) u_cos (
            .clk (clk),
            .en  (advance),
            .x   (px_reg[i]),
            .y   (acos_y[i])
        );
    end

    // distance product and circle test
    always_comb
    begin
        logic [63:0]  prod;
        search_side_t fin;
        fin  = dec_reg[ACOS_BITS];
        prod = {32'd0, radius_reg} * {32'd0, fin.theta};
        result_next.central_angle = fin.theta;
        result_next.distance      = prod[63:30];
        result_next.inside_res    = !fin.invalid && (fin.theta <= fin.radius);
        result_next.invalid       = fin.invalid;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            for (int j = 0; j < SERIES_LAT; j++)
                fv_reg[j] <= 1'b0;
            for (int i = 0; i <= ACOS_BITS; i++)
                dv_reg[i] <= 1'b0;
            for (int i = 0; i < ACOS_BITS; i++)
            begin
                pv_reg[i] <= 1'b0;
                for (int j = 0; j < SERIES_LAT; j++)
                    dlyv_reg[i][j] <= 1'b0;
            end
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v0_reg    <= item_valid;
            v1_reg    <= v0_reg;
            v2_reg    <= v1_reg;
            fv_reg[0] <= v2_reg;
            for (int j = 1; j < SERIES_LAT; j++)
                fv_reg[j] <= fv_reg[j-1];
            v3_reg    <= fv_reg[SERIES_LAT-1];
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            dv_reg[0] <= v5_reg;
            for (int i = 0; i < ACOS_BITS; i++)
            begin
                pv_reg[i]      <= dv_reg[i];
                dlyv_reg[i][0] <= pv_reg[i];
                for (int j = 1; j < SERIES_LAT; j++)
                    dlyv_reg[i][j] <= dlyv_reg[i][j-1];
                dv_reg[i+1] <= dlyv_reg[i][SERIES_LAT-1];
            end
            result_valid_reg <= dv_reg[ACOS_BITS];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int a = 0; a < 3; a++)
            begin
                quad0_reg[a] <= quad0_next[a];
                r0_reg[a]    <= r0_next[a];
                quad1_reg[a] <= quad0_reg[a];
                ph_reg[a]    <= ph_next[a];
                pl_reg[a]    <= pl_next[a];
                quad2_reg[a] <= quad1_reg[a];
                x_reg[a]     <= x_next[a];
                s_reg[a]     <= s_next[a];
                c_reg[a]     <= c_next[a];
            end
            rad0_reg <= item.circle_radius;
            rad1_reg <= rad0_reg;
            rad2_reg <= rad1_reg;
            fside_reg[0].quad[0] <= quad2_reg[0];
            fside_reg[0].quad[1] <= quad2_reg[1];
            fside_reg[0].quad[2] <= quad2_reg[2];
            fside_reg[0].radius  <= rad2_reg;
            for (int j = 1; j < SERIES_LAT; j++)
                fside_reg[j] <= fside_reg[j-1];
            rad3_reg <= fside_reg[SERIES_LAT-1].radius;
            // cos(dlon) * cos(lat1) and sin(lat1) * sin(lat2)
            m1_reg   <= qmul(c_reg[2], c_reg[0]);
            m2_reg   <= qmul(s_reg[0], s_reg[1]);
            c2_reg   <= c_reg[1];
            rad4_reg <= rad3_reg;
            m3_reg   <= qmul(m1_reg, c2_reg);
            m2b_reg  <= m2_reg;
            rad5_reg <= rad4_reg;
            dec_reg[0] <= dec0_next;
            for (int i = 0; i < ACOS_BITS; i++)
            begin
                prep_reg[i]     <= prep_next[i];
                px_reg[i]       <= px_next[i];
                dly_reg[i][0]   <= prep_reg[i];
                for (int j = 1; j < SERIES_LAT; j++)
                    dly_reg[i][j] <= dly_reg[i][j-1];
                dec_reg[i+1]    <= dec_next[i];
            end
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[sv/gcd_series.sv]
// ----------------------------------------------------------------------------
// gcd_series
// Pipelined taylor series for sine or cosine of a q30 angle in [0, pi/2].
// ----------------------------------------------------------------------------
module gcd_series #(
    parameter bit IS_SIN = 1'b0
) (
    input  logic        clk,
    input  logic        en,
    input  logic [30:0] x,
    output logic [30:0] y
);
    import gcd_pkg::*;

    logic [31:0]        x2_reg   [SERIES_TERMS+1];
    logic [31:0]        term_reg [SERIES_TERMS+1];
    logic signed [34:0] sum_reg  [SERIES_TERMS+1];

    logic [32:0]        pa_reg   [SERIES_TERMS];
    logic [31:0]        x2a_reg  [SERIES_TERMS];
    logic signed [34:0] suma_reg [SERIES_TERMS];
    logic [32:0]        pb_reg   [SERIES_TERMS];
    logic [31:0]        q0_reg   [SERIES_TERMS];
    logic [31:0]        x2b_reg  [SERIES_TERMS];
    logic signed [34:0] sumb_reg [SERIES_TERMS];
    logic [30:0]        y_reg;

    logic [63:0]        sq_next;
    logic [32:0]        pa_next   [SERIES_TERMS];
    logic [31:0]        q0_next   [SERIES_TERMS];
    logic [31:0]        term_next [SERIES_TERMS];
    logic signed [34:0] sum_next  [SERIES_TERMS];
    logic [30:0]        y_next;

    // per term: product, reciprocal estimate, correction and accumulate
    always_comb
    begin
        logic [63:0] prod;
        logic [65:0] rprod;
        logic [33:0] rem;
        logic [33:0] dv;
        logic [32:0] recip;
        sq_next = {33'd0, x} * {33'd0, x};
        for (int k = 0; k < SERIES_TERMS; k++)
        begin
            dv    = IS_SIN ? 34'(SIN_DIV[k]) : 34'(COS_DIV[k]);
            recip = IS_SIN ? SIN_RECIP[k] : COS_RECIP[k];
            prod  = {32'd0, term_reg[k]} * {32'd0, x2_reg[k]};
            pa_next[k] = prod[62:30];
            rprod = {33'd0, pa_reg[k]} * {33'd0, recip};
            q0_next[k] = rprod[64:33];
            rem = {1'b0, pb_reg[k]} - ({2'd0, q0_reg[k]} * dv);
            term_next[k] = (rem >= dv) ? q0_reg[k] + 32'd1 : q0_reg[k];
            if (k % 2 == 0)
                sum_next[k] = sumb_reg[k] - $signed({3'd0, term_next[k]});
            else
                sum_next[k] = sumb_reg[k] + $signed({3'd0, term_next[k]});
        end
        // clamp to [0, 1.0]
        if (sum_reg[SERIES_TERMS] < 0)
            y_next = '0;
        else if (sum_reg[SERIES_TERMS] > $signed({3'd0, ONE_Q30}))
            y_next = ONE_Q30[30:0];
        else
            y_next = sum_reg[SERIES_TERMS][30:0];
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x2_reg[0]   <= sq_next[61:30];
            term_reg[0] <= IS_SIN ? {1'b0, x} : ONE_Q30;
            sum_reg[0]  <= IS_SIN ? $signed({4'd0, x}) : $signed({3'd0, ONE_Q30});
            for (int k = 0; k < SERIES_TERMS; k++)
            begin
                pa_reg[k]     <= pa_next[k];
                x2a_reg[k]    <= x2_reg[k];
                suma_reg[k]   <= sum_reg[k];
                q0_reg[k]     <= q0_next[k];
                pb_reg[k]     <= pa_reg[k];
                x2b_reg[k]    <= x2a_reg[k];
                sumb_reg[k]   <= suma_reg[k];
                term_reg[k+1] <= term_next[k];
                x2_reg[k+1]   <= x2b_reg[k];
                sum_reg[k+1]  <= sum_next[k];
            end
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

[sv/gcd_checker.sv]
// ----------------------------------------------------------------------------
// gcd_checker
// Port-level checks of the great-circle distance unit, bound to the top level.
// ----------------------------------------------------------------------------
module gcd_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_stall,
    input logic             result_valid,
    input logic             result_stall,
    input gcd_pkg::result_t result
);
    import gcd_pkg::*;

    // a held result word keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // input only waits behind a blocked result
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("item stalled without a blocked result");

    // a clamped argument never reports inside
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.inside_res && result.invalid))
        else $error("inside flag set on invalid word");

    // central angle stays within [0, pi]
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.central_angle <= PI_Q30)
        else $error("central angle beyond pi");

endmodule

bind great_circle_distance_unit gcd_checker u_gcd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
